>>> hw/rtl/mffd_pkg.sv
// ----------------------------------------------------------------------------
// mffd_pkg
// Types, register map and fixed-point constants of the motor feedback decoder.
// ----------------------------------------------------------------------------
package mffd_pkg;

	localparam int SLOT_REGS = 4;

	localparam logic [2:0] REG_MOTOR_COUNT = 3'd0;
	localparam logic [2:0] REG_SLOT0_ID    = 3'd1;
	localparam logic [2:0] REG_SLOT1_ID    = 3'd2;
	localparam logic [2:0] REG_SLOT2_ID    = 3'd3;
	localparam logic [2:0] REG_SLOT3_ID    = 3'd4;
	localparam logic [2:0] REG_ACTIVE_TYPE = 3'd5;

	localparam logic [4:0] TYPE_FEEDBACK       = 5'h02;
	localparam logic [4:0] ACTIVE_TYPE_DEFAULT = 5'd24;

	// position: 4096 * (2514 * p - 1257 * 65535) / (100 * 65535)
	localparam logic [11:0] POS_GAIN  = 12'd2514;
	localparam logic [26:0] POS_OFFS  = 27'd82377495;
	localparam logic [39:0] POS_HALF  = 40'd3276750;
	localparam logic [23:0] POS_RECIP = 24'd10737419;
	localparam int          POS_SHIFT = 30;

	// velocity: 1024 * (100 * v - 50 * 65535) / 65535
	localparam logic [6:0]  VEL_GAIN = 7'd100;
	localparam logic [21:0] VEL_OFFS = 22'd3276750;
	localparam logic [39:0] VEL_HALF = 40'd32767;

	// torque: 4096 * (110 * t - 55 * 65535) / (10 * 65535)
	localparam logic [6:0]  TRQ_GAIN  = 7'd110;
	localparam logic [21:0] TRQ_OFFS  = 22'd3604425;
	localparam logic [39:0] TRQ_HALF  = 40'd327675;
	localparam logic [20:0] TRQ_RECIP = 21'd209716;
	localparam int          TRQ_SHIFT = 21;

	typedef struct packed {
		logic [2:0]                     motor_count;
		logic [SLOT_REGS-1:0][7:0]      slot_id;
		logic [4:0]                     active_report_type;
	} cfg_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  slot;
		logic        pos_neg;
		logic [26:0] pos_mag;
		logic        vel_neg;
		logic [21:0] vel_mag;
		logic        trq_neg;
		logic [21:0] trq_mag;
		logic [15:0] temp;
		logic [1:0]  state;
		logic [5:0]  faults;
	} frame_t;

	// floor(x / 65535) by folding the upper bits back onto the lower half
	function automatic logic [23:0] div65535(input logic [39:0] x);
		logic [24:0] s;
		logic [24:0] q;
		logic [16:0] r;
		s = {1'b0, x[39:16]} + {9'd0, x[15:0]};
		q = {1'b0, x[39:16]} + {16'd0, s[24:16]};
		r = {8'd0, s[24:16]} + {1'b0, s[15:0]};
		if (r >= 17'd65535) begin
			q = q + 25'd1;
		end
		return q[23:0];
	endfunction

endpackage

>>> hw/rtl/mffd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mffd_cfg_regs
// Register file for slot count, slot ids and active-report type; APB access.
// ----------------------------------------------------------------------------
module mffd_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output mffd_pkg::cfg_t  cfg
);
	import mffd_pkg::*;

	logic [2:0] motor_count_q;
	logic [7:0] slot_id_q [SLOT_REGS];
	logic [4:0] active_type_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_count_q <= 3'd0;
			for (int i = 0; i < SLOT_REGS; i++) begin
				slot_id_q[i] <= 8'd0;
			end
			active_type_q <= ACTIVE_TYPE_DEFAULT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MOTOR_COUNT: motor_count_q <= pwdata[2:0];
				REG_SLOT0_ID:    slot_id_q[0]  <= pwdata[7:0];
				REG_SLOT1_ID:    slot_id_q[1]  <= pwdata[7:0];
				REG_SLOT2_ID:    slot_id_q[2]  <= pwdata[7:0];
				REG_SLOT3_ID:    slot_id_q[3]  <= pwdata[7:0];
				REG_ACTIVE_TYPE: active_type_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MOTOR_COUNT: prdata = {29'd0, motor_count_q};
			REG_SLOT0_ID:    prdata = {24'd0, slot_id_q[0]};
			REG_SLOT1_ID:    prdata = {24'd0, slot_id_q[1]};
			REG_SLOT2_ID:    prdata = {24'd0, slot_id_q[2]};
			REG_SLOT3_ID:    prdata = {24'd0, slot_id_q[3]};
			REG_ACTIVE_TYPE: prdata = {27'd0, active_type_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.motor_count        = motor_count_q;
		cfg.active_report_type = active_type_q;
		for (int i = 0; i < SLOT_REGS; i++) begin
			cfg.slot_id[i] = slot_id_q[i];
		end
	end

endmodule

>>> hw/rtl/mffd_front.sv
// ----------------------------------------------------------------------------
// mffd_front
// Field extraction, slot match, type check and offset removal into stage one.
// ----------------------------------------------------------------------------
module mffd_front #(
	parameter int SLOTS = 4
) (
	input  logic              clk,
	input  logic              load,
	input  mffd_pkg::cfg_t    cfg,
	input  logic [28:0]       ext_id,
	input  logic [15:0]       pos_raw,
	input  logic [15:0]       vel_raw,
	input  logic [15:0]       torque_raw,
	input  logic [15:0]       temp_raw,
	output mffd_pkg::frame_t  frame_s1
);
	import mffd_pkg::*;

	logic [4:0]  frm_type;
	logic [7:0]  frm_mid;
	logic        found;
	logic [1:0]  slot;
	logic        type_ok;
	logic [27:0] pos_prod;
	logic [22:0] vel_prod;
	logic [22:0] trq_prod;
	frame_t      frame;

	assign frm_type = ext_id[28:24];
	assign frm_mid  = ext_id[15:8];
	assign type_ok  = (frm_type == TYPE_FEEDBACK) || (frm_type == cfg.active_report_type);

	always_comb begin
		found = 1'b0;
		slot  = 2'd0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if ((3'(i) < cfg.motor_count) && (cfg.slot_id[i] == frm_mid)) begin
				found = 1'b1;
				slot  = 2'(i);
			end
		end
	end

	assign pos_prod = {12'd0, pos_raw} * {16'd0, POS_GAIN};
	assign vel_prod = {7'd0, vel_raw} * {16'd0, VEL_GAIN};
	assign trq_prod = {7'd0, torque_raw} * {16'd0, TRQ_GAIN};

	always_comb begin
		frame.hit  = found & type_ok;
		frame.slot = slot;
		if (pos_prod >= {1'b0, POS_OFFS}) begin
			frame.pos_neg = 1'b0;
			frame.pos_mag = 27'(pos_prod - {1'b0, POS_OFFS});
		end else begin
			frame.pos_neg = 1'b1;
			frame.pos_mag = 27'({1'b0, POS_OFFS} - pos_prod);
		end
		if (vel_prod >= {1'b0, VEL_OFFS}) begin
			frame.vel_neg = 1'b0;
			frame.vel_mag = 22'(vel_prod - {1'b0, VEL_OFFS});
		end else begin
			frame.vel_neg = 1'b1;
			frame.vel_mag = 22'({1'b0, VEL_OFFS} - vel_prod);
		end
		if (trq_prod >= {1'b0, TRQ_OFFS}) begin
			frame.trq_neg = 1'b0;
			frame.trq_mag = 22'(trq_prod - {1'b0, TRQ_OFFS});
		end else begin
			frame.trq_neg = 1'b1;
			frame.trq_mag = 22'({1'b0, TRQ_OFFS} - trq_prod);
		end
		frame.temp   = temp_raw;
		frame.state  = ext_id[23:22];
		frame.faults = ext_id[21:16];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_s1 <= frame;
		end
	end

endmodule

>>> hw/rtl/mffd_scale.sv
// ----------------------------------------------------------------------------
// mffd_scale
// Rounded constant division of the three codes and the result register.
// ----------------------------------------------------------------------------
module mffd_scale (
	input  logic               clk,
	input  logic               load,
	input  mffd_pkg::frame_t   frame_s1,
	output logic               accepted,
	output logic [1:0]         motor_slot,
	output logic signed [16:0] position,
	output logic signed [16:0] velocity,
	output logic signed [15:0] torque,
	output logic [15:0]        temperature_tenths,
	output logic [1:0]         motor_state,
	output logic [5:0]         fault_bits
);
	import mffd_pkg::*;

	logic [23:0] pos_w;
	logic [46:0] pos_prod;
	logic [15:0] pos_q;
	logic [23:0] vel_w;
	logic [15:0] vel_q;
	logic [23:0] trq_w;
	logic [38:0] trq_prod;
	logic [14:0] trq_q;
	logic [16:0] pos_n;
	logic [16:0] vel_n;
	logic [15:0] trq_n;

	assign pos_w    = div65535(40'({frame_s1.pos_mag, 12'd0}) + POS_HALF);
	assign pos_prod = {24'd0, pos_w[22:0]} * {23'd0, POS_RECIP};
	assign pos_q    = 16'(pos_prod >> POS_SHIFT);

	assign vel_w = div65535(40'({frame_s1.vel_mag, 10'd0}) + VEL_HALF);
	assign vel_q = vel_w[15:0];

	assign trq_w    = div65535(40'({frame_s1.trq_mag, 12'd0}) + TRQ_HALF);
	assign trq_prod = {21'd0, trq_w[17:0]} * {18'd0, TRQ_RECIP};
	assign trq_q    = 15'(trq_prod >> TRQ_SHIFT);

	assign pos_n = frame_s1.pos_neg ? 17'(-{1'b0, pos_q}) : {1'b0, pos_q};
	assign vel_n = frame_s1.vel_neg ? 17'(-{1'b0, vel_q}) : {1'b0, vel_q};
	assign trq_n = frame_s1.trq_neg ? 16'(-{1'b0, trq_q}) : {1'b0, trq_q};

	always_ff @(posedge clk) begin
		if (load) begin
			if (frame_s1.hit) begin
				accepted           <= 1'b1;
				motor_slot         <= frame_s1.slot;
				position           <= pos_n;
				velocity           <= vel_n;
				torque             <= trq_n;
				temperature_tenths <= frame_s1.temp;
				motor_state        <= frame_s1.state;
				fault_bits         <= frame_s1.faults;
			end else begin
				accepted           <= 1'b0;
				motor_slot         <= 2'd0;
				position           <= 17'sd0;
				velocity           <= 17'sd0;
				torque             <= 16'sd0;
				temperature_tenths <= 16'd0;
				motor_state        <= 2'd0;
				fault_bits         <= 6'd0;
			end
		end
	end

endmodule

>>> hw/rtl/motor_feedback_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder_top: decodes motor feedback frames.
// Pipeline: two register stages, frame_s1 then the result registers,
// which raise out_valid. Throughput: one transaction per cycle while
// out_stall is low, through the two stages (prescale and slot match,
// then constant division and rounding).
// Reset: configuration to defaults, pipeline emptied; no clearing pass.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder_top #(
	parameter int MOTOR_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [28:0]        ext_id,
	input  logic [15:0]        pos_raw,
	input  logic [15:0]        vel_raw,
	input  logic [15:0]        torque_raw,
	input  logic [15:0]        temp_raw,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic [1:0]         motor_slot,
	output logic signed [16:0] position,
	output logic signed [16:0] velocity,
	output logic signed [15:0] torque,
	output logic [15:0]        temperature_tenths,
	output logic [1:0]         motor_state,
	output logic [5:0]         fault_bits
);
	import mffd_pkg::*;

	localparam int LIVE_SLOTS = (MOTOR_SLOTS < SLOT_REGS) ? MOTOR_SLOTS : SLOT_REGS;

	cfg_t   cfg;
	frame_t frame_s1;
	logic   v_s1;
	logic   v_s2;
	logic   out_ready;
	logic   load_s1;
	logic   load_s2;

	assign out_ready = !v_s2 || !out_stall;
	assign in_stall  = v_s1 && !out_ready;
	assign load_s1   = in_valid && !in_stall;
	assign load_s2   = v_s1 && out_ready;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= 1'b1;
			end else if (load_s2) begin
				v_s1 <= 1'b0;
			end
			if (load_s2) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	mffd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mffd_front #(
		.SLOTS (LIVE_SLOTS)
	) u_front (
		.clk        (clk),
		.load       (load_s1),
		.cfg        (cfg),
		.ext_id     (ext_id),
		.pos_raw    (pos_raw),
		.vel_raw    (vel_raw),
		.torque_raw (torque_raw),
		.temp_raw   (temp_raw),
		.frame_s1   (frame_s1)
	);

	mffd_scale u_scale (
		.clk                (clk),
		.load               (load_s2),
		.frame_s1           (frame_s1),
		.accepted           (accepted),
		.motor_slot         (motor_slot),
		.position           (position),
		.velocity           (velocity),
		.torque             (torque),
		.temperature_tenths (temperature_tenths),
		.motor_state        (motor_state),
		.fault_bits         (fault_bits)
	);

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transaction did not reach stage one");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && out_stall)
		else $error("input stalled while pipeline has room");

	a_reject_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> position == 17'sd0 && velocity == 17'sd0 &&
			torque == 16'sd0 && motor_slot == 2'd0)
		else $error("rejected frame carries nonzero result");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position <= 17'sd51487 && position >= -17'sd51487)
		else $error("position out of range");
`endif

endmodule
